>>> sv/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BTA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("boundary tag allocator assertion failed");

// Next-cycle implication, disabled while in reset.
`define BTA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("boundary tag allocator assertion failed");

`endif

>>> sv/bta_pkg.sv
// Shared constants, types and reset-time tag contents for the allocator.
// Depends on nothing; every file but bta_ram and assert_macros.svh imports it.
package bta_pkg;

  localparam int HEAP_BYTES  = 1048576;
  localparam int TAG_WORDS   = HEAP_BYTES / 4;
  localparam int TAG_AW      = $clog2(TAG_WORDS);
  localparam int BA_W        = $clog2(HEAP_BYTES) + 1;
  localparam int TAG_W       = BA_W;
  localparam int SZ_W        = (BA_W + 1 > 22) ? BA_W + 1 : 22;
  localparam int REQ_W       = 21;
  localparam int PA_W        = 20;
  localparam int CHUNK_W     = 21;
  localparam int INIT_CHUNK  = 4096;
  localparam int MIN_BLOCK   = 16;
  localparam int PROLOGUE_BP = 8;
  localparam int FIRST_BP    = 16;
  localparam bit INIT_FITS   = (FIRST_BP + INIT_CHUNK <= HEAP_BYTES);
  localparam int INIT_HEAP_END = INIT_FITS ? FIRST_BP + INIT_CHUNK : FIRST_BP;
  localparam int INIT_NFS    = INIT_FITS ? FIRST_BP : PROLOGUE_BP;
  localparam int INIT_WRITES = INIT_FITS ? 5 : 3;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(INIT_CHUNK);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_NONE = 1'b1;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE,
    S_SRCH_LOOP, S_SRCH_CHK,
    S_GROW, S_GROW_W0, S_GROW_W1, S_GROW_W2,
    S_MRG_RP, S_MRG_RN, S_MRG_DEC, S_MRG_W0, S_MRG_W1,
    S_PLC_W0, S_PLC_W1, S_PLC_W2, S_PLC_W3,
    S_FREE_LOOP, S_FREE_CHK, S_FREE_W0, S_FREE_W1,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [TAG_AW-1:0] addr;
    logic [TAG_W-1:0]  wdata;
  } mem_req_t;

  typedef struct packed {
    logic [PA_W-1:0] result_addr;
    logic            status;
  } res_t;

  // Tag words written after reset: prologue, initial free chunk, epilogue.
  function automatic logic [TAG_AW-1:0] init_addr(input logic [2:0] n);
    logic [TAG_AW-1:0] a;
    case (n)
      3'd0:    a = TAG_AW'(1);
      3'd1:    a = TAG_AW'(2);
      3'd2:    a = TAG_AW'(3);
      3'd3:    a = TAG_AW'((FIRST_BP + INIT_CHUNK - 8) / 4);
      3'd4:    a = TAG_AW'((FIRST_BP + INIT_CHUNK - 4) / 4);
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic [TAG_W-1:0] init_data(input logic [2:0] n);
    logic [TAG_W-1:0] d;
    case (n)
      3'd0:    d = TAG_W'(9);
      3'd1:    d = TAG_W'(9);
      3'd2:    d = INIT_FITS ? TAG_W'(INIT_CHUNK) : TAG_W'(1);
      3'd3:    d = TAG_W'(INIT_CHUNK);
      3'd4:    d = TAG_W'(1);
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

>>> sv/bta_req_if.sv
// Request channel: valid/ready handshake carrying one allocate or free item.
// Depends on bta_pkg.
interface bta_req_if import bta_pkg::*;;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [REQ_W-1:0] request_bytes;
  logic [PA_W-1:0]  block_addr;

  modport source (output valid, cmd, request_bytes, block_addr, input ready);
  modport sink   (input valid, cmd, request_bytes, block_addr, output ready);
endinterface

>>> sv/bta_rsp_if.sv
// Result channel: valid/ready handshake carrying one result item.
// Depends on bta_pkg.
interface bta_rsp_if import bta_pkg::*;;
  logic            valid;
  logic            ready;
  logic [PA_W-1:0] result_addr;
  logic            status;

  modport source (output valid, result_addr, status, input ready);
  modport sink   (input valid, result_addr, status, output ready);
endinterface

>>> sv/bta_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
module bta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> sv/bta_agen.sv
// Shared tag address unit: byte address plus size minus a tag offset,
// turned into a tag word index. Depends on bta_pkg.
module bta_agen import bta_pkg::*; (
  input  logic [BA_W-1:0]   base,
  input  logic [SZ_W-1:0]   offs,
  input  logic              sub8,
  output logic [TAG_AW-1:0] idx
);
  logic [SZ_W:0] sum;

  always_comb begin
    sum = {{(SZ_W + 1 - BA_W){1'b0}}, base} + {1'b0, offs}
          - (sub8 ? (SZ_W + 1)'(8) : (SZ_W + 1)'(4));
    idx = sum[TAG_AW+1:2];
  end
endmodule

>>> sv/bta_ctrl.sv
// Sequencer for reset-time init, search, grow, merge, place and free over the tag store.
// Depends on bta_pkg and bta_agen.
module bta_ctrl import bta_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               cmd,
  input  logic [REQ_W-1:0]   request_bytes,
  input  logic [PA_W-1:0]    block_addr,
  input  logic [CHUNK_W-1:0] chunk,
  input  logic               res_ready,
  input  logic [TAG_W-1:0]   rdata,
  output logic               ready,
  output logic               done,
  output res_t               res,
  output mem_req_t           mem
);
  state_t state_r, state_nxt;
  logic [BA_W-1:0]  bp_r, bp_nxt, heap_end_r, heap_end_nxt, nfs_r, nfs_nxt;
  logic [SZ_W-1:0]  size_r, size_nxt, asize_r, asize_nxt;
  logic [PA_W-1:0]  addr_r, addr_nxt;
  logic [TAG_W-1:0] prev_r, prev_nxt;
  logic             pass_r, pass_nxt, grow_r, grow_nxt, split_r, split_nxt;
  logic [2:0]       init_r, init_nxt;
  res_t             res_r, res_nxt;

  logic [BA_W-1:0]   ag_base;
  logic [SZ_W-1:0]   ag_offs;
  logic              ag_sub8;
  logic [TAG_AW-1:0] ag_idx;

  logic [SZ_W-1:0] tag_sz, prev_sz, ext, rem, use_sz;
  logic [SZ_W:0]   gsize;
  logic [SZ_W+1:0] gend;
  logic            in_range, split_w, pf, nf;

  bta_agen u_agen (.base(ag_base), .offs(ag_offs), .sub8(ag_sub8), .idx(ag_idx));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      init_r     <= '0;
      heap_end_r <= BA_W'(INIT_HEAP_END);
      nfs_r      <= BA_W'(INIT_NFS);
    end else begin
      state_r    <= state_nxt;
      init_r     <= init_nxt;
      heap_end_r <= heap_end_nxt;
      nfs_r      <= nfs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bp_r    <= bp_nxt;
    size_r  <= size_nxt;
    asize_r <= asize_nxt;
    addr_r  <= addr_nxt;
    prev_r  <= prev_nxt;
    pass_r  <= pass_nxt;
    grow_r  <= grow_nxt;
    split_r <= split_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    bp_nxt       = bp_r;
    heap_end_nxt = heap_end_r;
    nfs_nxt      = nfs_r;
    size_nxt     = size_r;
    asize_nxt    = asize_r;
    addr_nxt     = addr_r;
    prev_nxt     = prev_r;
    pass_nxt     = pass_r;
    grow_nxt     = grow_r;
    split_nxt    = split_r;
    init_nxt     = init_r;
    res_nxt      = res_r;
    ag_base      = bp_r;
    ag_offs      = '0;
    ag_sub8      = 1'b0;
    mem.we       = 1'b0;
    mem.addr     = ag_idx;
    mem.wdata    = '0;
    ready        = 1'b0;
    done         = 1'b0;

    tag_sz   = SZ_W'({rdata[TAG_W-1:3], 3'b000});
    prev_sz  = SZ_W'({prev_r[TAG_W-1:3], 3'b000});
    in_range = (bp_r < heap_end_r);
    ext      = (asize_r > SZ_W'(chunk)) ? asize_r : SZ_W'(chunk);
    gsize    = ({1'b0, ext} + (SZ_W + 1)'(4)) & ~(SZ_W + 1)'(7);
    gend     = (SZ_W + 2)'(heap_end_r) + (SZ_W + 2)'(gsize);
    rem      = size_r - asize_r;
    split_w  = (rem >= SZ_W'(MIN_BLOCK));
    use_sz   = split_r ? asize_r : size_r;
    pf       = !prev_r[0];
    nf       = !rdata[0];

    case (state_r)
      S_INIT: begin
        mem.we    = 1'b1;
        mem.addr  = init_addr(init_r);
        mem.wdata = init_data(init_r);
        init_nxt  = init_r + 3'd1;
        if (init_r == 3'(INIT_WRITES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ready = 1'b1;
        if (start) begin
          res_nxt.result_addr = '0;
          res_nxt.status      = STATUS_OK;
          addr_nxt            = block_addr;
          if (cmd == CMD_FREE) begin
            bp_nxt    = BA_W'(FIRST_BP);
            state_nxt = S_FREE_LOOP;
          end else if (request_bytes == '0) begin
            res_nxt.status = STATUS_NONE;
            state_nxt      = S_DONE;
          end else begin
            if (request_bytes <= REQ_W'(8)) begin
              asize_nxt = SZ_W'(MIN_BLOCK);
            end else begin
              asize_nxt = (SZ_W'(request_bytes) + SZ_W'(15)) & ~SZ_W'(7);
            end
            bp_nxt    = nfs_r;
            pass_nxt  = 1'b0;
            state_nxt = S_SRCH_LOOP;
          end
        end
      end
      S_SRCH_LOOP: begin
        if (in_range && (!pass_r || bp_r != nfs_r)) begin
          state_nxt = S_SRCH_CHK;
        end else if (!pass_r) begin
          bp_nxt   = BA_W'(PROLOGUE_BP);
          pass_nxt = 1'b1;
        end else begin
          state_nxt = S_GROW;
        end
      end
      S_SRCH_CHK: begin
        if (tag_sz == '0) begin
          if (!pass_r) begin
            bp_nxt    = BA_W'(PROLOGUE_BP);
            pass_nxt  = 1'b1;
            state_nxt = S_SRCH_LOOP;
          end else begin
            state_nxt = S_GROW;
          end
        end else if (!rdata[0] && asize_r <= tag_sz) begin
          size_nxt  = tag_sz;
          state_nxt = S_PLC_W0;
        end else begin
          bp_nxt    = BA_W'(bp_r + tag_sz);
          state_nxt = S_SRCH_LOOP;
        end
      end
      S_GROW: begin
        if (gend > (SZ_W + 2)'(HEAP_BYTES)) begin
          res_nxt.status = STATUS_NONE;
          state_nxt      = S_DONE;
        end else begin
          size_nxt  = SZ_W'(gsize);
          bp_nxt    = heap_end_r;
          state_nxt = S_GROW_W0;
        end
      end
      S_GROW_W0: begin
        mem.we    = 1'b1;
        mem.wdata = TAG_W'(size_r);
        state_nxt = S_GROW_W1;
      end
      S_GROW_W1: begin
        ag_offs   = size_r;
        ag_sub8   = 1'b1;
        mem.we    = 1'b1;
        mem.wdata = TAG_W'(size_r);
        state_nxt = S_GROW_W2;
      end
      S_GROW_W2: begin
        ag_offs      = size_r;
        mem.we       = 1'b1;
        mem.wdata    = TAG_W'(1);
        heap_end_nxt = BA_W'(heap_end_r + size_r);
        grow_nxt     = 1'b1;
        state_nxt    = S_MRG_RP;
      end
      S_MRG_RP: begin
        ag_sub8   = 1'b1;
        state_nxt = S_MRG_RN;
      end
      S_MRG_RN: begin
        ag_offs   = size_r;
        prev_nxt  = rdata;
        state_nxt = S_MRG_DEC;
      end
      S_MRG_DEC: begin
        if (!pf && !nf) begin
          state_nxt = grow_r ? S_PLC_W0 : S_DONE;
        end else begin
          size_nxt  = size_r + (pf ? prev_sz : '0) + (nf ? tag_sz : '0);
          bp_nxt    = pf ? BA_W'(bp_r - prev_sz) : bp_r;
          nfs_nxt   = pf ? BA_W'(bp_r - prev_sz) : bp_r;
          state_nxt = S_MRG_W0;
        end
      end
      S_MRG_W0: begin
        mem.we    = 1'b1;
        mem.wdata = TAG_W'(size_r);
        state_nxt = S_MRG_W1;
      end
      S_MRG_W1: begin
        ag_offs   = size_r;
        ag_sub8   = 1'b1;
        mem.we    = 1'b1;
        mem.wdata = TAG_W'(size_r);
        state_nxt = grow_r ? S_PLC_W0 : S_DONE;
      end
      S_PLC_W0: begin
        split_nxt           = split_w;
        mem.we              = 1'b1;
        mem.wdata           = TAG_W'(split_w ? asize_r : size_r) | TAG_W'(1);
        res_nxt.result_addr = PA_W'(bp_r);
        state_nxt           = S_PLC_W1;
      end
      S_PLC_W1: begin
        ag_offs   = use_sz;
        ag_sub8   = 1'b1;
        mem.we    = 1'b1;
        mem.wdata = TAG_W'(use_sz) | TAG_W'(1);
        state_nxt = split_r ? S_PLC_W2 : S_DONE;
      end
      S_PLC_W2: begin
        ag_offs   = asize_r;
        mem.we    = 1'b1;
        mem.wdata = TAG_W'(rem);
        state_nxt = S_PLC_W3;
      end
      S_PLC_W3: begin
        ag_offs   = size_r;
        ag_sub8   = 1'b1;
        mem.we    = 1'b1;
        mem.wdata = TAG_W'(rem);
        state_nxt = S_DONE;
      end
      S_FREE_LOOP: begin
        state_nxt = in_range ? S_FREE_CHK : S_DONE;
      end
      S_FREE_CHK: begin
        if (tag_sz == '0) begin
          state_nxt = S_DONE;
        end else if (bp_r == BA_W'(addr_r)) begin
          size_nxt  = tag_sz;
          state_nxt = rdata[0] ? S_FREE_W0 : S_DONE;
        end else if (bp_r > BA_W'(addr_r)) begin
          state_nxt = S_DONE;
        end else begin
          bp_nxt    = BA_W'(bp_r + tag_sz);
          state_nxt = S_FREE_LOOP;
        end
      end
      S_FREE_W0: begin
        mem.we    = 1'b1;
        mem.wdata = TAG_W'(size_r);
        state_nxt = S_FREE_W1;
      end
      S_FREE_W1: begin
        ag_offs   = size_r;
        ag_sub8   = 1'b1;
        mem.we    = 1'b1;
        mem.wdata = TAG_W'(size_r);
        grow_nxt  = 1'b0;
        state_nxt = S_MRG_RP;
      end
      S_DONE: begin
        if (res_ready) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res = res_r;
endmodule

>>> sv/boundary_tag_heap_allocator_top.sv
// Top level of the boundary-tag heap allocator.
// Depends on bta_pkg, bta_req_if, bta_rsp_if, bta_ram and bta_ctrl.
//
// Usage: in_ch carries one item per request: cmd selects allocate or free,
// request_bytes is the payload size for an allocate and block_addr the
// payload address for a free. out_ch returns exactly one item per request:
// result_addr of the new block (zero when none) and status, which is set
// when an allocate of zero bytes or one that would pass the heap limit
// gives no block. cfg_wr_en with cfg_wr_data sets the minimum growth step
// in bytes; the user must see that it is written only while the block is
// idle, as the block itself does not enforce it.
// Tag store: a single-port RAM with a registered read, so each block
// visited by a search or a walk takes a loop state and a check state.
// One item is in progress at a time; in_ch.ready is high only when idle.
// Reset: synchronous, active low. After reset the sequencer writes the
// prologue, the initial free chunk and the epilogue into the tag store,
// with in_ch.ready low.
// Stall: a finished result waits in the output register; the block may
// accept the next item meanwhile, but holds its next result until the
// output register is free.
module boundary_tag_heap_allocator_top import bta_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  bta_req_if.sink            in_ch,
  bta_rsp_if.source          out_ch,
  input  logic               cfg_wr_en,
  input  logic [CHUNK_W-1:0] cfg_wr_data
);
  logic [CHUNK_W-1:0] chunk_r;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_r;
  logic               ready, done, res_ready;
  res_t               res;
  mem_req_t           mem;
  logic [TAG_W-1:0]   rdata;

  // Growth step register: plain write port, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= CHUNK_RESET;
    end else if (cfg_wr_en) begin
      chunk_r <= cfg_wr_data;
    end
  end

  // The sequencer only hands over a result when the output slot is free.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_r <= res;
    end
  end

  // Tag store: one word per 4 heap bytes holding size and allocated bit.
  bta_ram #(.WIDTH(TAG_W), .DEPTH(TAG_WORDS)) u_tags (
    .clk   (clk),
    .we    (mem.we),
    .addr  (mem.addr),
    .wdata (mem.wdata),
    .rdata (rdata)
  );

  bta_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (in_ch.valid && ready),
    .cmd           (in_ch.cmd),
    .request_bytes (in_ch.request_bytes),
    .block_addr    (in_ch.block_addr),
    .chunk         (chunk_r),
    .res_ready     (res_ready),
    .rdata         (rdata),
    .ready         (ready),
    .done          (done),
    .res           (res),
    .mem           (mem)
  );

  assign in_ch.ready        = ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_addr = out_r.result_addr;
  assign out_ch.status      = out_r.status;
endmodule

>>> sv/bta_checker.sv
// Port-level checks for the allocator top, attached by bind.
// Depends on bta_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bta_checker import bta_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [PA_W-1:0] result_addr,
  input logic            status
);
  // A held result keeps its payload until taken.
  `BTA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(result_addr) && $stable(status))
  // A refused allocate never carries an address.
  `BTA_ASSERT_NOW(a_none_zero, out_valid && status == STATUS_NONE, result_addr == '0)
  // Block payload addresses are double-word aligned.
  `BTA_ASSERT_NOW(a_aligned, out_valid, result_addr[2:0] == 3'b000)
  // An accept always moves the sequencer out of idle, so ready drops after an accept.
  `BTA_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)
endmodule

bind boundary_tag_heap_allocator_top bta_checker u_bta_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .result_addr (out_ch.result_addr),
  .status      (out_ch.status)
);
